[hw/rtl/assert_macros.svh]
// Assertion helpers used by the RTL drive module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed");

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/scrmd_pkg.sv]
`timescale 1ns / 1ps

package scrmd_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLEW_INC      = 2'd0,
    CFG_RAMP_PERIOD   = 2'd1,
    CFG_IDLE_TIMEOUT  = 2'd2,
    CFG_DEFAULT_SPEED = 2'd3
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [7:0]  RST_SLEW_INC      = 8'd8;
  localparam logic [9:0]  RST_RAMP_PERIOD   = 10'd30;
  localparam logic [15:0] RST_IDLE_TIMEOUT  = 16'd1400;
  localparam logic [7:0]  RST_DEFAULT_SPEED = 8'd150;

  // Character codes of the command line.
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_R     = 8'h52;

  // Idle counter saturation value.
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

endpackage

[hw/rtl/scrmd_in_if.sv]
`timescale 1ns / 1ps

// Input channel: a serial byte or a millisecond tick.
interface scrmd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

[hw/rtl/scrmd_out_if.sv]
`timescale 1ns / 1ps

// Output channel: bridge drive state after each input transaction.
interface scrmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_duty;
  logic       left_forward;
  logic       left_reverse;
  logic [7:0] right_duty;
  logic       right_forward;
  logic       right_reverse;
  logic       ramping;

  modport source (
    output valid, output left_duty, output left_forward, output left_reverse,
    output right_duty, output right_forward, output right_reverse,
    output ramping, input ready
  );
  modport sink (
    input valid, input left_duty, input left_forward, input left_reverse,
    input right_duty, input right_forward, input right_reverse,
    input ramping, output ready
  );
endinterface

[hw/rtl/serial_command_ramped_motor_drive.sv]
`timescale 1ns / 1ps
// Serial-commanded dual H-bridge drive with a slew-rate limited ramp. Each input
// transaction is a received byte (op 0) or a millisecond tick (op 1) and yields exactly
// one output transaction with the duty and direction lines of both sides and the ramping
// flag, all taken after that input. Lines such as "F120", "B-40", "L" or "S" end with a
// newline; the value saturates at PWM_MAX and a lone letter uses default_speed. The block
// takes one transaction per clock: the line parser, ramp divider, speed step and idle
// timer all update in a single pass from the state registers into the output register,
// so input ready is low only while that output register holds a transaction that the
// sink has not taken. Configuration writes take effect at the next clock edge and are
// meant to be issued while no transaction is in flight.

`include "assert_macros.svh"

module serial_command_ramped_motor_drive #(
  parameter int MAX_LINE = 10,
  parameter int PWM_MAX  = 255
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scrmd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scrmd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  scrmd_in_if.sink                         in_i,
  scrmd_out_if.source                      out_o
);
  import scrmd_pkg::*;

  localparam int LenW = $clog2(MAX_LINE + 1);
  localparam logic [LenW-1:0]  MaxLen  = LenW'(MAX_LINE);
  localparam logic [LenW-1:0]  LenOne  = LenW'(1);
  localparam logic [7:0]       PwmMax  = 8'(PWM_MAX);
  localparam logic signed [8:0] PwmMaxS = 9'(PWM_MAX);

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } parse_phase_e;

  // Configuration registers.
  logic [7:0]  slew_inc_q;
  logic [9:0]  ramp_period_q;
  logic [15:0] idle_timeout_q;
  logic [7:0]  default_speed_q;

  // Line parser state.
  logic [7:0]      letter_q, letter_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      mag_q, mag_d;
  logic            neg_q, neg_d;
  parse_phase_e    phase_q, phase_d;

  // Drive state.
  logic signed [8:0] tl_q, tl_d, tr_q, tr_d;
  logic signed [8:0] sl_q, sl_d, sr_q, sr_d;
  logic [9:0]        div_q, div_d;
  logic [15:0]       idle_q, idle_d;

  // Output register.
  logic       out_valid_q;
  logic [7:0] l_duty_q, r_duty_q;
  logic       l_fwd_q, l_rev_q, r_fwd_q, r_rev_q, ramping_q;

  logic accept;

  // Temporaries of the single update pass.
  logic [7:0]        c;
  logic              is_digit;
  logic [11:0]       mag_acc;
  logic [7:0]        val_mag;
  logic              val_neg;
  logic signed [8:0] v_pos, v_neg, v_fwd, v_rev;
  logic              ramp_pre, ramp_post;
  logic [10:0]       div_inc;
  logic [15:0]       idle_inc;

  // Moves a speed toward its target by the ramp step without overshoot.
  function automatic logic signed [8:0] move_toward(input logic signed [8:0] cur,
                                                    input logic signed [8:0] tgt,
                                                    input logic [7:0] step);
    logic signed [10:0] cur_w, tgt_w, up, dn;
    logic signed [8:0]  res;
    cur_w = 11'(cur);
    tgt_w = 11'(tgt);
    up    = cur_w + $signed({3'b000, step});
    dn    = cur_w - $signed({3'b000, step});
    if (cur < tgt) begin
      res = (up > tgt_w) ? tgt : up[8:0];
    end else if (cur > tgt) begin
      res = (dn < tgt_w) ? tgt : dn[8:0];
    end else begin
      res = cur;
    end
    return res;
  endfunction

  // Handshake: the output register frees itself when the sink takes it.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Value carried by a finished command line.
  always_comb begin
    if (len_q == LenOne) begin
      val_mag = (default_speed_q > PwmMax) ? PwmMax : default_speed_q;
      val_neg = 1'b0;
    end else begin
      val_mag = mag_q;
      val_neg = neg_q;
    end
    v_pos = $signed({1'b0, val_mag});
    v_neg = -v_pos;
    v_fwd = val_neg ? v_neg : v_pos;
    v_rev = val_neg ? v_pos : v_neg;
  end

  // One update pass for the accepted transaction.
  always_comb begin
    letter_d  = letter_q;
    len_d     = len_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    phase_d   = phase_q;
    tl_d      = tl_q;
    tr_d      = tr_q;
    sl_d      = sl_q;
    sr_d      = sr_q;
    div_d     = div_q;
    idle_d    = idle_q;
    c         = in_i.rx_byte;
    is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    mag_acc   = {4'b0000, mag_q} * 12'd10 + {8'h00, c[3:0]};
    ramp_pre  = (sl_q != tl_q) || (sr_q != tr_q);
    div_inc   = {1'b0, div_q} + 11'd1;
    ramp_post = ramp_pre;
    idle_inc  = idle_q;

    if (accept) begin
      if (!in_i.op) begin
        if (c == CHAR_NL) begin
          // End of line: set targets, then start a fresh line.
          if (len_q != '0) begin
            case (letter_q)
              CHAR_F: begin tl_d = v_fwd; tr_d = v_fwd; end
              CHAR_B: begin tl_d = v_rev; tr_d = v_rev; end
              CHAR_L: begin tl_d = v_rev; tr_d = v_fwd; end
              CHAR_R: begin tl_d = v_fwd; tr_d = v_rev; end
              default: begin tl_d = '0; tr_d = '0; end
            endcase
          end
          letter_d = '0;
          len_d    = '0;
          mag_d    = '0;
          neg_d    = 1'b0;
          phase_d  = PH_LEAD;
          idle_d   = '0;
        end else if (c >= CHAR_SPACE) begin
          if (len_q >= MaxLen) begin
            // Overlong line is discarded.
            letter_d = '0;
            len_d    = '0;
            mag_d    = '0;
            neg_d    = 1'b0;
            phase_d  = PH_LEAD;
          end else begin
            if (len_q == '0) begin
              letter_d = c;
            end else if (is_digit && phase_q != PH_DONE) begin
              mag_d   = (mag_acc > {4'h0, PwmMax}) ? PwmMax : mag_acc[7:0];
              phase_d = PH_DIGITS;
            end else if (phase_q == PH_LEAD) begin
              if (c == CHAR_SPACE) begin
                phase_d = PH_LEAD;
              end else if (c == CHAR_PLUS) begin
                phase_d = PH_SIGN;
              end else if (c == CHAR_MINUS) begin
                neg_d   = 1'b1;
                phase_d = PH_SIGN;
              end else begin
                phase_d = PH_DONE;
              end
            end else begin
              phase_d = PH_DONE;
            end
            len_d = len_q + LenOne;
          end
        end
      end else begin
        // Millisecond tick: ramp divider and speed step.
        if (ramp_pre) begin
          if (div_inc >= {1'b0, ramp_period_q}) begin
            div_d = '0;
            sl_d  = move_toward(sl_q, tl_q, slew_inc_q);
            sr_d  = move_toward(sr_q, tr_q, slew_inc_q);
          end else begin
            div_d = div_inc[9:0];
          end
        end else begin
          div_d = '0;
        end
        // Idle timer runs only once the speeds have settled.
        ramp_post = (sl_d != tl_q) || (sr_d != tr_q);
        if (ramp_post) begin
          idle_d = '0;
        end else begin
          idle_inc = (idle_q != IDLE_MAX) ? idle_q + 16'd1 : idle_q;
          if (idle_inc > idle_timeout_q) begin
            tl_d   = '0;
            tr_d   = '0;
            idle_d = '0;
          end else begin
            idle_d = idle_inc;
          end
        end
      end
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slew_inc_q      <= RST_SLEW_INC;
      ramp_period_q   <= RST_RAMP_PERIOD;
      idle_timeout_q  <= RST_IDLE_TIMEOUT;
      default_speed_q <= RST_DEFAULT_SPEED;
      letter_q        <= '0;
      len_q           <= '0;
      mag_q           <= '0;
      neg_q           <= 1'b0;
      phase_q         <= PH_LEAD;
      tl_q            <= '0;
      tr_q            <= '0;
      sl_q            <= '0;
      sr_q            <= '0;
      div_q           <= '0;
      idle_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLEW_INC:      slew_inc_q      <= cfg_data_i[7:0];
          CFG_RAMP_PERIOD:   ramp_period_q   <= cfg_data_i[9:0];
          CFG_IDLE_TIMEOUT:  idle_timeout_q  <= cfg_data_i[15:0];
          CFG_DEFAULT_SPEED: default_speed_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      letter_q <= letter_d;
      len_q    <= len_d;
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      phase_q  <= phase_d;
      tl_q     <= tl_d;
      tr_q     <= tr_d;
      sl_q     <= sl_d;
      sr_q     <= sr_d;
      div_q    <= div_d;
      idle_q   <= idle_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload reflects the state after the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      l_duty_q  <= sl_d[8] ? 8'(-sl_d) : sl_d[7:0];
      l_fwd_q   <= (sl_d > 9'sd0);
      l_rev_q   <= sl_d[8];
      r_duty_q  <= sr_d[8] ? 8'(-sr_d) : sr_d[7:0];
      r_fwd_q   <= (sr_d > 9'sd0);
      r_rev_q   <= sr_d[8];
      ramping_q <= (sl_d != tl_d) || (sr_d != tr_d);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.left_duty     = l_duty_q;
  assign out_o.left_forward  = l_fwd_q;
  assign out_o.left_reverse  = l_rev_q;
  assign out_o.right_duty    = r_duty_q;
  assign out_o.right_forward = r_fwd_q;
  assign out_o.right_reverse = r_rev_q;
  assign out_o.ramping       = ramping_q;

  // Speeds never leave the duty range.
  `ASSERT_ALWAYS(a_speed_range, clk_i, rst_ni,
    (sl_q <= PwmMaxS) && (sl_q >= -PwmMaxS) && (sr_q <= PwmMaxS) && (sr_q >= -PwmMaxS))
  // A pending ramping flag matches the live speed and target state.
  `ASSERT_IMPLIES(a_ramp_flag, clk_i, rst_ni, out_valid_q,
    ramping_q == ((sl_q != tl_q) || (sr_q != tr_q)))
  // The idle timer only counts once both sides have settled.
  `ASSERT_IMPLIES(a_idle_settled, clk_i, rst_ni, idle_q != '0,
    (sl_q == tl_q) && (sr_q == tr_q))
  // The line buffer never grows past its limit.
  `ASSERT_ALWAYS(a_line_len, clk_i, rst_ni, len_q <= MaxLen)

endmodule
